FILE: hw/rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/pdrot_pkg.sv
`timescale 1ns / 1ps
package pdrot_pkg;

   localparam int YAW_W   = 23;
   localparam int TURN_W  = 14;
   localparam int GAIN_W  = 16;
   localparam int LIMIT_W = 8;
   localparam int DUTY_W  = 8;
   localparam int ERR_W   = YAW_W + 1;
   localparam int DIFF_W  = ERR_W + 1;
   localparam int MULA_W  = GAIN_W;
   localparam int PROD_W  = MULA_W + 1 + DIFF_W;
   localparam int ACC_W   = PROD_W + 1;
   localparam int MAG_SH  = 12;
   localparam int SCALE_SH = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam int STEP_W  = 4;

   localparam logic [GAIN_W-1:0]  PROP_RST  = 16'd1280;
   localparam logic [GAIN_W-1:0]  DERIV_RST = 16'd128;
   localparam logic [GAIN_W-1:0]  SCALE_RST = 16'd44281;
   localparam logic [LIMIT_W-1:0] LIMIT_RST = 8'd150;
   localparam logic [TURN_W-1:0]  TURN_RST  = 14'd1440;

   localparam logic signed [YAW_W-1:0] YAW_MIN = {1'b1, {(YAW_W-1){1'b0}}};
   localparam logic signed [YAW_W-1:0] YAW_MAX = {1'b0, {(YAW_W-1){1'b1}}};
   localparam logic [DUTY_W-1:0] SPEED_FLOOR = 8'd50;
   localparam logic [DUTY_W-1:0] DUTY_MAX    = 8'd255;
   localparam logic signed [ERR_W-1:0] NEAR_HI = ERR_W'(160);
   localparam logic signed [ERR_W-1:0] NEAR_LO = -NEAR_HI;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCALE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN  = 3'd4;

   // program steps, sample steps run in consecutive order
   localparam logic [STEP_W-1:0] ST_ERR      = 4'd0;
   localparam logic [STEP_W-1:0] ST_MUL_P    = 4'd1;
   localparam logic [STEP_W-1:0] ST_MUL_D    = 4'd2;
   localparam logic [STEP_W-1:0] ST_MUL_LIM  = 4'd3;
   localparam logic [STEP_W-1:0] ST_MAG      = 4'd4;
   localparam logic [STEP_W-1:0] ST_SPEED    = 4'd5;
   localparam logic [STEP_W-1:0] ST_MUL_DUTY = 4'd6;
   localparam logic [STEP_W-1:0] ST_DRIVE    = 4'd7;
   localparam logic [STEP_W-1:0] ST_START    = 4'd8;

   typedef enum logic [1:0] {
      MA_PROP  = 2'd0,
      MA_DERIV = 2'd1,
      MA_LIMIT = 2'd2,
      MA_SPEED = 2'd3
   } mul_a_type;

   typedef enum logic [1:0] {
      MB_ERR   = 2'd0,
      MB_DIFF  = 2'd1,
      MB_SCALE = 2'd2
   } mul_b_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef enum logic {
      JMP_NONE     = 1'b0,
      JMP_IF_START = 1'b1
   } jump_type;

   typedef struct packed {
      logic              mul_en;
      mul_a_type         ma;
      mul_b_type         mb;
      acc_op_type        acc;
      logic              ld_err;
      logic              ld_mag;
      logic              ld_speed;
      logic              ld_drive;
      logic              ld_goal;
      logic              done;
      jump_type          jc;
      logic [STEP_W-1:0] target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '0;
      case (step)
         ST_ERR: begin
            w.ld_err = 1'b1;
            w.jc     = JMP_IF_START;
            w.target = ST_START;
         end
         ST_MUL_P: begin
            w.mul_en = 1'b1;
            w.ma     = MA_PROP;
            w.mb     = MB_ERR;
         end
         ST_MUL_D: begin
            w.mul_en = 1'b1;
            w.ma     = MA_DERIV;
            w.mb     = MB_DIFF;
            w.acc    = ACC_LOAD;
         end
         ST_MUL_LIM: begin
            w.mul_en = 1'b1;
            w.ma     = MA_LIMIT;
            w.mb     = MB_SCALE;
            w.acc    = ACC_ADD;
         end
         ST_MAG: begin
            w.ld_mag = 1'b1;
         end
         ST_SPEED: begin
            w.ld_speed = 1'b1;
         end
         ST_MUL_DUTY: begin
            w.mul_en = 1'b1;
            w.ma     = MA_SPEED;
            w.mb     = MB_SCALE;
         end
         ST_DRIVE: begin
            w.ld_drive = 1'b1;
            w.done     = 1'b1;
         end
         ST_START: begin
            w.ld_goal = 1'b1;
            w.done    = 1'b1;
         end
         default: begin
            w.done = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: hw/rtl/pdrot_chan_if.sv
`timescale 1ns / 1ps
interface pdrot_req_if;
   import pdrot_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    op;
   logic signed [YAW_W-1:0] yaw;

   modport source (output valid, output op, output yaw, input ready);
   modport sink (input valid, input op, input yaw, output ready);
endinterface

interface pdrot_rsp_if;
   import pdrot_pkg::*;

   logic              valid;
   logic              ready;
   logic              left_fwd;
   logic              left_rev;
   logic [DUTY_W-1:0] left_duty;
   logic              right_fwd;
   logic              right_rev;
   logic [DUTY_W-1:0] right_duty;

   modport source (output valid, output left_fwd, output left_rev, output left_duty,
                   output right_fwd, output right_rev, output right_duty, input ready);
   modport sink (input valid, input left_fwd, input left_rev, input left_duty,
                 input right_fwd, input right_rev, input right_duty, output ready);
endinterface

FILE: hw/rtl/pdrot_seq.sv
`timescale 1ns / 1ps
module pdrot_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 op_start,
   input  logic                 rsp_hold,
   output logic                 busy,
   output pdrot_pkg::ucode_type ctl
);
   import pdrot_pkg::*;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   ucode_type         word;
   logic              go;

   assign word = ucode_rom(step_ff);
   // a finishing step waits while the previous word is still unclaimed
   assign go   = busy_ff && !(word.done && rsp_hold);
   assign ctl  = go ? word : '0;
   assign busy = busy_ff;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (accept) begin
         busy_in = 1'b1;
         step_in = ST_ERR;
      end else if (go) begin
         if (word.done) begin
            busy_in = 1'b0;
         end else if (word.jc == JMP_IF_START && op_start) begin
            step_in = word.target;
         end else begin
            step_in = step_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= ST_ERR;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

endmodule

FILE: hw/rtl/pd_rotate_in_place_motor_drive_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// PD rotate-in-place drive: a start word (op 0) latches the goal heading as yaw plus
// turn_angle, saturated, and returns both motors idle; a sample word (op 1) runs the PD
// law on goal minus yaw and returns direction pins and duty for both motors. A small
// microcode program steps one shared 17x25 multiplier through the gains, the speed
// bound and the duty scaling. One word is worked on at a time; the result sits in an
// output register, so the next word is taken as soon as the program finishes, even
// while the result waits.
module pd_rotate_in_place_motor_drive_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   pdrot_req_if.sink                             req_ch,
   pdrot_rsp_if.source                           rsp_ch,
   input  logic                                  csr_wr_en,
   input  logic [pdrot_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pdrot_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pdrot_pkg::*;

   // configuration
   logic [GAIN_W-1:0]         prop_ff, deriv_ff, scale_ff;
   logic [LIMIT_W-1:0]        limit_ff;
   logic signed [TURN_W-1:0]  turn_ff;

   // controller state and datapath
   logic signed [YAW_W-1:0]   goal_ff, yaw_ff;
   logic signed [ERR_W-1:0]   last_ff, e_ff, e_in;
   logic signed [DIFF_W-1:0]  d_ff;
   logic                      op_ff;
   logic [MULA_W-1:0]         mul_a;
   logic signed [DIFF_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]  mul_p, prod_ff;
   logic signed [ACC_W-1:0]   acc_ff, acc_abs;
   logic [DUTY_W-1:0]         mag_ff, mag_sat, upper_ff, speed_ff, spd_min, spd_flr, duty;
   logic signed [ERR_W:0]     goal_sum;
   logic signed [YAW_W-1:0]   goal_sat;
   logic                      near, pos;

   // result register
   logic                      rsp_valid_ff;
   logic                      lf_ff, lr_ff, rf_ff, rr_ff;
   logic [DUTY_W-1:0]         ld_ff, rd_ff;

   logic                      accept, seq_busy;
   ucode_type                 ctl;
   logic                      pins_idle, pins_turn;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !seq_busy && !reset;

   pdrot_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .op_start (!op_ff),
      .rsp_hold (rsp_valid_ff && !rsp_ch.ready),
      .busy     (seq_busy),
      .ctl      (ctl)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_ff  <= PROP_RST;
         deriv_ff <= DERIV_RST;
         scale_ff <= SCALE_RST;
         limit_ff <= LIMIT_RST;
         turn_ff  <= TURN_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PROP:  prop_ff  <= csr_wdata;
            CSR_DERIV: deriv_ff <= csr_wdata;
            CSR_SCALE: scale_ff <= csr_wdata;
            CSR_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_TURN:  turn_ff  <= csr_wdata[TURN_W-1:0];
            default: ;
         endcase
      end
   end

   // shared multiplier, operands picked by the control word
   always_comb begin
      case (ctl.ma)
         MA_PROP:  mul_a = prop_ff;
         MA_DERIV: mul_a = deriv_ff;
         MA_LIMIT: mul_a = {{(MULA_W-LIMIT_W){1'b0}}, limit_ff};
         MA_SPEED: mul_a = {{(MULA_W-DUTY_W){1'b0}}, speed_ff};
         default:  mul_a = '0;
      endcase
      case (ctl.mb)
         MB_ERR:   mul_b = {e_ff[ERR_W-1], e_ff};
         MB_DIFF:  mul_b = d_ff;
         MB_SCALE: mul_b = {{(DIFF_W-GAIN_W){1'b0}}, scale_ff};
         default:  mul_b = '0;
      endcase
   end

   assign mul_p = $signed({1'b0, mul_a}) * mul_b;

   assign e_in     = {goal_ff[YAW_W-1], goal_ff} - {yaw_ff[YAW_W-1], yaw_ff};
   assign goal_sum = {{2{yaw_ff[YAW_W-1]}}, yaw_ff}
                   + {{(ERR_W+1-TURN_W){turn_ff[TURN_W-1]}}, turn_ff};
   assign goal_sat = (goal_sum[ERR_W:YAW_W-1] == '0 || goal_sum[ERR_W:YAW_W-1] == '1)
                   ? goal_sum[YAW_W-1:0]
                   : (goal_sum[ERR_W] ? YAW_MIN : YAW_MAX);

   // magnitude of the PD sum in whole units, saturated to a byte (upper bound fits a byte)
   assign acc_abs = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
   assign mag_sat = (|acc_abs[ACC_W-1:MAG_SH+DUTY_W]) ? DUTY_MAX
                  : acc_abs[MAG_SH+DUTY_W-1:MAG_SH];

   assign spd_min = (mag_ff < upper_ff) ? mag_ff : upper_ff;
   assign spd_flr = (spd_min < SPEED_FLOOR) ? SPEED_FLOOR : spd_min;
   assign near    = (e_ff > NEAR_LO) && (e_ff < NEAR_HI);
   assign pos     = e_ff > $signed(ERR_W'(0));
   assign duty    = (|prod_ff[PROD_W-1:SCALE_SH+DUTY_W]) ? DUTY_MAX
                  : prod_ff[SCALE_SH+DUTY_W-1:SCALE_SH];

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_ch.op;
         yaw_ff <= req_ch.yaw;
      end
      if (ctl.ld_err) begin
         e_ff <= e_in;
         d_ff <= {e_in[ERR_W-1], e_in} - {last_ff[ERR_W-1], last_ff};
      end
      if (ctl.mul_en) begin
         prod_ff <= mul_p;
      end
      case (ctl.acc)
         ACC_LOAD: acc_ff <= {prod_ff[PROD_W-1], prod_ff};
         ACC_ADD:  acc_ff <= acc_ff + {prod_ff[PROD_W-1], prod_ff};
         default: ;
      endcase
      if (ctl.ld_mag) begin
         mag_ff   <= mag_sat;
         upper_ff <= prod_ff[SCALE_SH+DUTY_W-1:SCALE_SH];
      end
      if (ctl.ld_speed) begin
         speed_ff <= near ? (spd_flr >> 1) : spd_flr;
      end
      if (ctl.ld_drive) begin
         lf_ff <= (duty != '0) && pos;
         lr_ff <= (duty != '0) && !pos;
         rf_ff <= (duty != '0) && !pos;
         rr_ff <= (duty != '0) && pos;
         ld_ff <= duty;
         rd_ff <= duty;
      end
      if (ctl.ld_goal) begin
         lf_ff <= 1'b0;
         lr_ff <= 1'b0;
         rf_ff <= 1'b0;
         rr_ff <= 1'b0;
         ld_ff <= '0;
         rd_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         goal_ff      <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctl.ld_goal) begin
            goal_ff <= goal_sat;
         end
         if (ctl.ld_drive) begin
            last_ff <= e_ff;
         end
         if (ctl.done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.left_fwd   = lf_ff;
   assign rsp_ch.left_rev   = lr_ff;
   assign rsp_ch.left_duty  = ld_ff;
   assign rsp_ch.right_fwd  = rf_ff;
   assign rsp_ch.right_rev  = rr_ff;
   assign rsp_ch.right_duty = rd_ff;

   assign pins_idle = !lf_ff && !lr_ff && (rd_ff == '0);
   assign pins_turn = (lf_ff != lr_ff) && (lf_ff == rr_ff) && (rd_ff == ld_ff);

   `ASSERT_NEXT(a_accept_runs_first_step, clock, reset, accept, ctl.ld_err)
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, ctl.done, !rsp_valid_ff || rsp_ch.ready)
   `ASSERT_IMPLIES(a_idle_pins, clock, reset, rsp_valid_ff && ld_ff == '0, pins_idle)
   `ASSERT_IMPLIES(a_opposite_turn, clock, reset, rsp_valid_ff && ld_ff != '0, pins_turn)

endmodule
